### rtl/lio_pkg.sv
// ----------------------------------------------------------------------------
// lio_pkg
// Shared types and constants for the largest island after one flip block.
// ----------------------------------------------------------------------------
`default_nettype none
package lio_pkg;
  localparam int unsigned MaxSideDef = 32;
  localparam int unsigned SideW = 6;
  localparam int unsigned AreaW = 11;

  typedef enum logic [4:0] {
    ST_LOAD, ST_CLR, ST_SCAN, ST_SCAN_RD, ST_POP, ST_POP_RD, ST_NB, ST_NB_RD,
    ST_NB_CHK, ST_AREA, ST_WSCAN, ST_WNB, ST_WNB_RD, ST_WNB_AQ, ST_WNB_AR,
    ST_WDONE, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic start_scan;
    logic scan_next;
    logic seed;
    logic pop;
    logic nb_next;
    logic nb_push;
    logic area_done;
    logic wstart;
    logic wnb_start;
    logic wnb_next;
    logic wnb_add;
    logic wdone;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic total_done;
    logic clr_last;
    logic scan_land;
    logic scan_unlab;
    logic stack_empty;
    logic nb_valid;
    logic nb_last;
    logic nb_push_ok;
    logic wnb_lab;
    logic wnb_dup;
  } sts_t;
endpackage
`default_nettype wire

### rtl/lio_ctrl.sv
// ----------------------------------------------------------------------------
// lio_ctrl
// Controller: sequences load, clear, flood fill labeling and water scoring.
// ----------------------------------------------------------------------------
`default_nettype none
module lio_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_fire,
  input  wire                in_last,
  input  wire                out_taken,
  input  lio_pkg::sts_t      sts,
  output lio_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               out_valid
);
  lio_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lio_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      lio_pkg::ST_LOAD: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          if (in_last) state_nxt = lio_pkg::ST_CLR;
        end
      end
      lio_pkg::ST_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          cmd.start_scan = 1'b1;
          state_nxt = lio_pkg::ST_SCAN_RD;
        end
      end
      lio_pkg::ST_SCAN_RD: state_nxt = lio_pkg::ST_SCAN;
      lio_pkg::ST_SCAN: begin
        if (sts.total_done) begin
          cmd.wstart = 1'b1;
          state_nxt = lio_pkg::ST_WSCAN;
        end else if (sts.scan_land && sts.scan_unlab) begin
          cmd.seed = 1'b1;
          state_nxt = lio_pkg::ST_POP;
        end else begin
          cmd.scan_next = 1'b1;
          state_nxt = lio_pkg::ST_SCAN_RD;
        end
      end
      lio_pkg::ST_POP: begin
        if (sts.stack_empty) begin
          cmd.area_done = 1'b1;
          state_nxt = lio_pkg::ST_AREA;
        end else begin
          state_nxt = lio_pkg::ST_POP_RD;
        end
      end
      lio_pkg::ST_POP_RD: begin
        cmd.pop = 1'b1;
        state_nxt = lio_pkg::ST_NB;
      end
      lio_pkg::ST_NB: begin
        if (sts.nb_valid) begin
          state_nxt = lio_pkg::ST_NB_RD;
        end else if (sts.nb_last) begin
          state_nxt = lio_pkg::ST_POP;
        end else begin
          cmd.nb_next = 1'b1;
        end
      end
      lio_pkg::ST_NB_RD: state_nxt = lio_pkg::ST_NB_CHK;
      lio_pkg::ST_NB_CHK: begin
        if (sts.nb_push_ok) cmd.nb_push = 1'b1;
        if (sts.nb_last) begin
          state_nxt = lio_pkg::ST_POP;
        end else begin
          cmd.nb_next = 1'b1;
          state_nxt = lio_pkg::ST_NB;
        end
      end
      lio_pkg::ST_AREA: begin
        cmd.scan_next = 1'b1;
        state_nxt = lio_pkg::ST_SCAN_RD;
      end
      lio_pkg::ST_WSCAN: begin
        if (sts.total_done) begin
          state_nxt = lio_pkg::ST_OUT;
        end else begin
          cmd.wnb_start = 1'b1;
          state_nxt = lio_pkg::ST_WNB;
        end
      end
      lio_pkg::ST_WNB: begin
        if (sts.nb_valid) begin
          state_nxt = lio_pkg::ST_WNB_RD;
        end else if (sts.nb_last) begin
          state_nxt = lio_pkg::ST_WDONE;
        end else begin
          cmd.wnb_next = 1'b1;
        end
      end
      lio_pkg::ST_WNB_RD: state_nxt = lio_pkg::ST_WNB_AQ;
      lio_pkg::ST_WNB_AQ: state_nxt = lio_pkg::ST_WNB_AR;
      lio_pkg::ST_WNB_AR: begin
        if (sts.wnb_lab && !sts.wnb_dup) cmd.wnb_add = 1'b1;
        if (sts.nb_last) begin
          state_nxt = lio_pkg::ST_WDONE;
        end else begin
          cmd.wnb_next = 1'b1;
          state_nxt = lio_pkg::ST_WNB;
        end
      end
      lio_pkg::ST_WDONE: begin
        cmd.wdone = 1'b1;
        state_nxt = lio_pkg::ST_WSCAN;
      end
      lio_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_taken) begin
          cmd.finish = 1'b1;
          state_nxt = lio_pkg::ST_LOAD;
        end
      end
      default: state_nxt = lio_pkg::ST_LOAD;
    endcase
  end
endmodule
`default_nettype wire

### rtl/lio_dp.sv
// ----------------------------------------------------------------------------
// lio_dp
// Datapath: land, label, area and stack memories with scan and fill counters.
// ----------------------------------------------------------------------------
`default_nettype none
module lio_dp #(
  parameter int unsigned MAX_SIDE = lio_pkg::MaxSideDef
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire  [lio_pkg::SideW-1:0] grid_side,
  input  wire                       in_land,
  input  lio_pkg::cmd_t             cmd,
  output lio_pkg::sts_t             sts,
  output logic [lio_pkg::AreaW-1:0] max_area
);
  localparam int unsigned Cap = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AW = (Cap > 1) ? $clog2(Cap) : 1;
  localparam int unsigned CW = $clog2(Cap + 1);
  localparam int unsigned RW = $clog2(MAX_SIDE + 1);
  localparam int unsigned LW = $clog2(Cap + 1);
  localparam int unsigned AR = lio_pkg::AreaW;
  localparam int unsigned SW = AW + 2 * RW;

  logic             land_mem [Cap];
  logic [LW-1:0]    lab_mem  [Cap];
  logic [AR-1:0]    area_mem [Cap];
  logic [SW-1:0]    stk_mem  [Cap];

  logic [CW-1:0] loaded_r;
  logic [RW-1:0] side_r;
  logic [CW-1:0] total_r;
  logic [CW-1:0] k_r;
  logic [RW-1:0] kr_r, kc_r;
  logic [LW-1:0] label_r;
  logic [CW-1:0] sp_r;
  logic [AR-1:0] area_r, best_r, score_r;
  logic [CW-1:0] c_r;
  logic [RW-1:0] cr_r, cc_r;
  logic [1:0]    nb_r;
  logic [CW-1:0] nbk_r;
  logic [RW-1:0] nbr_r, nbc_r;
  logic          land_q, lab_z_q;
  logic [LW-1:0] lab_q;
  logic [AR-1:0] area_q;
  logic [SW-1:0] stk_q;
  logic [LW-1:0] seen_r [4];
  logic [3:0]    seen_v_r;

  logic [RW-1:0] side_now;
  logic [31:0]   side_sq;
  logic          nb_ok;
  logic [CW-1:0] nb_addr;
  logic [RW-1:0] nb_row, nb_col;
  logic [CW-1:0] base_k;
  logic [RW-1:0] base_r, base_c;
  logic          water_mode_r;
  logic [LW-1:0] lab_eff;
  logic          land_read;

  always_comb begin
    side_now = (grid_side == '0) ? RW'(1) : (32'(grid_side) > MAX_SIDE) ?
               RW'(MAX_SIDE) : RW'(grid_side);
    side_sq = 32'(side_now) * 32'(side_now);
  end

  assign base_k = water_mode_r ? k_r : c_r;
  assign base_r = water_mode_r ? kr_r : cr_r;
  assign base_c = water_mode_r ? kc_r : cc_r;

  // Neighbor order: down, up, right, left for fill; up, left, down, right for scoring.
  always_comb begin
    nb_ok = 1'b0;
    nb_addr = base_k;
    nb_row = base_r;
    nb_col = base_c;
    case ({water_mode_r, nb_r})
      3'b000, 3'b110: begin
        nb_ok = base_r + 1'b1 < side_r;
        nb_addr = base_k + CW'(side_r);
        nb_row = base_r + 1'b1;
      end
      3'b001, 3'b100: begin
        nb_ok = base_r != '0;
        nb_addr = base_k - CW'(side_r);
        nb_row = base_r - 1'b1;
      end
      3'b010, 3'b111: begin
        nb_ok = base_c + 1'b1 < side_r;
        nb_addr = base_k + 1'b1;
        nb_col = base_c + 1'b1;
      end
      3'b011, 3'b101: begin
        nb_ok = base_c != '0;
        nb_addr = base_k - 1'b1;
        nb_col = base_c - 1'b1;
      end
      default: ;
    endcase
  end

  logic          lab_we;
  logic [CW-1:0] lab_wa;
  logic [LW-1:0] lab_wd;
  logic          stk_we;
  logic [AW-1:0] stk_wa;
  logic [SW-1:0] stk_wd;

  always_comb begin
    lab_we = 1'b0;
    lab_wa = k_r;
    lab_wd = '0;
    if (cmd.clr) begin
      lab_we = 1'b1;
    end else if (cmd.seed) begin
      lab_we = 1'b1;
      lab_wd = label_r + 1'b1;
    end else if (cmd.nb_push) begin
      lab_we = 1'b1;
      lab_wa = nbk_r;
      lab_wd = label_r;
    end
    stk_we = cmd.seed || cmd.nb_push;
    stk_wa = cmd.seed ? '0 : sp_r[AW-1:0];
    stk_wd = cmd.seed ? {kr_r, kc_r, k_r[AW-1:0]} : {nbr_r, nbc_r, nbk_r[AW-1:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.load && loaded_r < CW'(side_sq) && 32'(loaded_r) < Cap)
      land_mem[loaded_r[AW-1:0]] <= in_land;
    if (lab_we) lab_mem[lab_wa[AW-1:0]] <= lab_wd;
    if (cmd.area_done) area_mem[label_r[AW-1:0] - 1'b1] <= area_r;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    land_read <= land_mem[nbk_r[AW-1:0]];
    land_q  <= land_mem[k_r[AW-1:0]];
    lab_q   <= lab_mem[nbk_r[AW-1:0]];
    lab_z_q <= lab_mem[k_r[AW-1:0]] == '0;
    area_q  <= area_mem[lab_q[AW-1:0] - 1'b1];
    stk_q   <= stk_mem[sp_r[AW-1:0] - 1'b1];
  end

  // Fill and scoring counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
      k_r <= '0;
      nb_r <= '0;
      sp_r <= '0;
      label_r <= '0;
      best_r <= '0;
      water_mode_r <= 1'b0;
      side_r <= RW'(1);
      total_r <= '0;
    end else begin
      if (cmd.load) begin
        if (loaded_r < CW'(side_sq) && 32'(loaded_r) < Cap) loaded_r <= loaded_r + 1'b1;
        side_r <= side_now;
        total_r <= CW'(side_sq);
        k_r <= '0;
        kr_r <= '0;
        kc_r <= '0;
        best_r <= '0;
        label_r <= '0;
        water_mode_r <= 1'b0;
      end
      if (cmd.clr) k_r <= k_r + 1'b1;
      if (cmd.start_scan) begin
        k_r <= '0; kr_r <= '0; kc_r <= '0;
      end
      if (cmd.scan_next || cmd.wdone) begin
        k_r <= k_r + 1'b1;
        if (kc_r + 1'b1 == side_r) begin
          kc_r <= '0; kr_r <= kr_r + 1'b1;
        end else begin
          kc_r <= kc_r + 1'b1;
        end
      end
      if (cmd.seed) begin
        label_r <= label_r + 1'b1;
        sp_r <= CW'(1);
        area_r <= '0;
      end
      if (cmd.pop) begin
        sp_r <= sp_r - 1'b1;
        c_r <= CW'(stk_q[AW-1:0]);
        cc_r <= stk_q[AW+RW-1:AW];
        cr_r <= stk_q[SW-1:AW+RW];
        area_r <= area_r + 1'b1;
        nb_r <= '0;
      end
      if (cmd.nb_next || cmd.wnb_next) nb_r <= nb_r + 1'b1;
      if (cmd.nb_push) sp_r <= sp_r + 1'b1;
      if (cmd.area_done && area_r > best_r) best_r <= area_r;
      if (cmd.wstart) begin
        water_mode_r <= 1'b1;
        k_r <= '0; kr_r <= '0; kc_r <= '0;
      end
      if (cmd.wnb_start) begin
        nb_r <= '0;
        score_r <= AR'(1);
        seen_v_r <= '0;
      end
      if (cmd.wnb_add) begin
        score_r <= score_r + area_q;
        seen_r[nb_r] <= lab_eff;
        seen_v_r[nb_r] <= 1'b1;
      end
      if (cmd.wdone && !sts.scan_land && score_r > best_r) best_r <= score_r;
      if (cmd.finish) loaded_r <= '0;
    end
  end

  assign lab_eff = (32'(nbk_r) < 32'(loaded_r) && land_read) ? lab_q : '0;

  always_ff @(posedge clk) begin
    nbk_r <= nb_addr;
    nbr_r <= nb_row;
    nbc_r <= nb_col;
  end

  always_comb begin
    sts = '0;
    sts.total_done = k_r >= total_r;
    sts.clr_last = k_r + 1'b1 >= total_r;
    sts.scan_land = land_q && (32'(k_r) < 32'(loaded_r));
    sts.scan_unlab = lab_z_q;
    sts.stack_empty = sp_r == '0;
    sts.nb_valid = nb_ok && !(water_mode_r && sts.scan_land);
    sts.nb_last = nb_r == 2'd3;
    sts.nb_push_ok = (32'(nbk_r) < 32'(loaded_r)) && land_read && lab_q == '0;
    sts.wnb_lab = lab_eff != '0;
    sts.wnb_dup = (seen_v_r[0] && seen_r[0] == lab_eff) ||
                  (seen_v_r[1] && seen_r[1] == lab_eff) ||
                  (seen_v_r[2] && seen_r[2] == lab_eff) ||
                  (seen_v_r[3] && seen_r[3] == lab_eff);
  end

  assign max_area = best_r;
endmodule
`default_nettype wire

### rtl/largest_island_after_one_flip.sv
// ----------------------------------------------------------------------------
// largest_island_after_one_flip
// Largest island achievable by flipping one water cell of a streamed grid.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// in_       slave      tdata[0] cell_is_land, tlast last_cell
// out_      master     tdata[10:0] max_area
// cfg_      APB        register 0 grid_side at address 0
// Cells are taken one per cycle while loading. After the last cell the label
// store is cleared and every cell is scanned. A fill visits each island cell
// and checks each of its in-grid neighbors. Scoring then visits every cell and
// reads the in-grid neighbors of each water cell. Input is stalled until the
// result transaction is taken; reset is synchronous.
`default_nettype none
module largest_island_after_one_flip #(
  parameter int unsigned MAX_SIDE = lio_pkg::MaxSideDef
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,  // [0] cell_is_land
  input  wire         in_tlast,
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata, // [10:0] max_area
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [1:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  logic [lio_pkg::SideW-1:0] side_r;
  lio_pkg::cmd_t cmd;
  lio_pkg::sts_t sts;
  logic busy;
  logic [lio_pkg::AreaW-1:0] area;

  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= lio_pkg::SideW'(32);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0) begin
      side_r <= cfg_pwdata[lio_pkg::SideW-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {26'd0, side_r} : 32'd0;

  assign in_tready = !busy;

  lio_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready), .in_last(in_tlast),
    .out_taken(out_tready), .sts(sts), .cmd(cmd), .busy(busy), .out_valid(out_tvalid)
  );

  lio_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
    .clk(clk), .rst_n(rst_n), .grid_side(side_r), .in_land(in_tdata[0]),
    .cmd(cmd), .sts(sts), .max_area(area)
  );

  assign out_tdata = {5'd0, area};
endmodule
`default_nettype wire

### sim/tb_largest_island_after_one_flip.sv
// ----------------------------------------------------------------------------
// tb_largest_island_after_one_flip
// Self-checking testbench for the largest island after one flip block.
// Grids are streamed in one cell per transaction, and each answer is checked
// against a flood-fill predictor kept in the testbench. A directed table runs
// first. It is followed by random grids of many sides and land densities,
// including truncated and overlong grids, under three idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_largest_island_after_one_flip;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxSide = 32;
  localparam int unsigned MaxCells = MaxSide * MaxSide;
  localparam int unsigned WatchLimit = 400000;
  localparam int DontCare = -1;
  localparam int NoWrite = -1;

  typedef struct {
    int side;
    bit land;
    bit last;
    int area;
  } grid_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;   // [0] cell_is_land, [7:1] zero
  logic        in_tlast;   // last_cell
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [10:0] max_area, [15:11] zero
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  largest_island_after_one_flip DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // Predictor state.
  logic [lio_pkg::SideW-1:0] side_reg;
  bit                        land_store[MaxCells];
  int unsigned               cells_in;

  logic [lio_pkg::AreaW-1:0] area_queue[$];
  int unsigned      errors;
  int unsigned      grids_done;
  int unsigned      cells_sent;
  int unsigned      tx_idle;
  int unsigned      rx_idle;
  int unsigned      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic int unsigned side_now();
    int unsigned s;
    s = side_reg;
    if (s == 0) s = 1;
    if (s > MaxSide) s = MaxSide;
    return s;
  endfunction

  function automatic bit land_at(int unsigned k);
    return k < cells_in && land_store[k];
  endfunction

  // Neighbor d (0 down, 1 up, 2 right, 3 left) of cell c on an n by n grid.
  function automatic bit neighbor(int unsigned c, int unsigned n, int d,
                                  output int unsigned nb);
    int unsigned r;
    int unsigned col;
    r = c / n;
    col = c % n;
    nb = c;
    case (d)
      0: begin if (r + 1 < n) begin nb = c + n; return 1; end end
      1: begin if (r > 0) begin nb = c - n; return 1; end end
      2: begin if (col + 1 < n) begin nb = c + 1; return 1; end end
      default: begin if (col > 0) begin nb = c - 1; return 1; end end
    endcase
    return 0;
  endfunction

  function automatic int unsigned best_flip_area(int unsigned n);
    int unsigned island_of[MaxCells];
    int unsigned size_of[MaxCells + 1];
    int unsigned pending[$];
    int unsigned seen[$];
    int unsigned total;
    int unsigned islands;
    int unsigned best;
    int unsigned sz;
    int unsigned c;
    int unsigned nb;
    int unsigned score;
    bit          dup;
    total = n * n;
    islands = 0;
    best = 0;
    for (int unsigned k = 0; k < total; k++) island_of[k] = 0;
    for (int unsigned k = 0; k < total; k++) begin
      if (land_at(k) && island_of[k] == 0) begin
        islands++;
        island_of[k] = islands;
        pending.push_back(k);
        sz = 0;
        while (pending.size() > 0) begin
          c = pending.pop_back();
          sz++;
          for (int d = 0; d < 4; d++)
            if (neighbor(c, n, d, nb) && land_at(nb) && island_of[nb] == 0) begin
              island_of[nb] = islands;
              pending.push_back(nb);
            end
        end
        size_of[islands] = sz;
        if (sz > best) best = sz;
      end
    end
    for (int unsigned k = 0; k < total; k++) begin
      if (!land_at(k)) begin
        score = 1;
        seen.delete();
        for (int d = 0; d < 4; d++)
          if (neighbor(k, n, d, nb) && island_of[nb] != 0) begin
            dup = 1'b0;
            foreach (seen[i]) if (seen[i] == island_of[nb]) dup = 1'b1;
            if (!dup) begin
              seen.push_back(island_of[nb]);
              score += size_of[island_of[nb]];
            end
          end
        if (score > best) best = score;
      end
    end
    return best;
  endfunction

  // Returns 1 and the predicted area when the accepted cell ends a grid.
  function automatic bit take_cell(bit land, bit last, output int unsigned area);
    int unsigned n;
    n = side_now();
    area = 0;
    if (cells_in < n * n) begin
      land_store[cells_in] = land;
      cells_in++;
    end
    if (!last) return 0;
    area = best_flip_area(n);
    cells_in = 0;
    return 1;
  endfunction

  task automatic send_cell(input bit land, input bit last, input int typed_area);
    int unsigned area;
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, land};
    in_tlast <= last;
    forever begin
      @(negedge clk);
      if (in_tready) break;
    end
    @(posedge clk);
    cells_sent++;
    if (take_cell(land, last, area)) begin
      grids_done++;
      area_queue.push_back(lio_pkg::AreaW'(typed_area >= 0 ? typed_area : int'(area)));
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (area_queue.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_side(input int value);
    wait_idle();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= 2'd0;
    cfg_pwdata <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    side_reg = lio_pkg::SideW'(value);
  endtask

  task automatic random_grid(input bit full_max);
    int unsigned pick;
    int unsigned n;
    int unsigned count;
    int unsigned density;
    int new_side;
    pick = $urandom_range(99);
    if (full_max) new_side = MaxSide;
    else if (pick < 75) new_side = $urandom_range(6, 1);
    else if (pick < 90) new_side = $urandom_range(12, 7);
    else new_side = $urandom_range(1) ? 0 : $urandom_range(16, 13);
    if (side_reg != lio_pkg::SideW'(new_side) || $urandom_range(3) == 0)
      write_side(new_side);
    n = side_now();
    pick = $urandom_range(99);
    if (full_max || pick < 80) count = n * n;
    else if (pick < 90) count = $urandom_range(n * n, 1);
    else count = n * n + $urandom_range(3, 1);
    density = $urandom_range(100);
    for (int unsigned i = 0; i < count; i++)
      send_cell($urandom_range(99) < density, i == count - 1, DontCare);
  endtask

  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (area_queue.size() == 0) report("unexpected max_area", int'(out_tdata[10:0]), 0);
      else begin
        logic [lio_pkg::AreaW-1:0] want;
        want = area_queue.pop_front();
        if (out_tdata[10:0] !== want)
          report("max_area", int'(out_tdata[10:0]), int'(want));
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("Watchdog expired with %0d results outstanding", area_queue.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    grid_row_t rows[$];
    int unsigned mode_items;
    rows = '{
      '{NoWrite, 1, 1, 2},
      '{0, 1, 1, 1},
      '{NoWrite, 0, 1, 1},
      '{1, 0, 0, DontCare}, '{NoWrite, 1, 0, DontCare}, '{NoWrite, 1, 1, 1},
      '{2, 1, 0, DontCare}, '{NoWrite, 1, 0, DontCare}, '{NoWrite, 1, 0, DontCare},
      '{NoWrite, 1, 1, 4},
      '{NoWrite, 1, 0, DontCare}, '{NoWrite, 0, 0, DontCare},
      '{NoWrite, 0, 0, DontCare}, '{NoWrite, 1, 1, 3},
      '{63, 0, 1, 1},
      '{33, 1, 0, DontCare}, '{NoWrite, 1, 1, 3},
      '{3, 1, 0, DontCare}, '{NoWrite, 1, 0, DontCare},
      '{2, 0, 0, DontCare}, '{NoWrite, 1, 1, DontCare}
    };
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    in_tlast = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = 2'd0;
    cfg_pwdata = 32'd0;
    side_reg = lio_pkg::SideW'(MaxSide);
    cells_in = 0;
    errors = 0;
    grids_done = 0;
    cells_sent = 0;
    tx_idle = 0;
    rx_idle = 0;
    foreach (land_store[i]) land_store[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].side != NoWrite) write_side(rows[i].side);
      send_cell(rows[i].land, rows[i].last, rows[i].area);
    end

    for (int m = 0; m < 3; m++) begin
      tx_idle = (m == 0) ? 8 : (m == 1) ? 69 : 0;
      rx_idle = (m == 0) ? 69 : (m == 1) ? 8 : 0;
      mode_items = cells_sent;
      random_grid(m == 0);
      while (cells_sent - mode_items < 400) random_grid(1'b0);
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Checked %0d grids from %0d cell transactions, sides 1 to 32,",
             grids_done, cells_sent);
    $display("with truncated and overlong grids under three idle patterns.");
    if (errors == 0 && area_queue.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
